/* rtl/wav_stream_decoder_mono_macros.svh */
// Assertion helpers shared by the decoder modules.
// Each use expects clk and arst_n in scope.
`ifndef WAV_STREAM_DECODER_MONO_MACROS_SVH
`define WAV_STREAM_DECODER_MONO_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define WSD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsd assertion failed");

// Next-cycle implication, off while reset is asserted
`define WSD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsd assertion failed");

`endif

/* rtl/wsd_pkg.sv */
package wsd_pkg;

	// Default channel limit
	localparam int MAX_CH_DEF = 8;

	// Chunk tags, little-endian byte order
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;

	// Format codes
	localparam logic [15:0] FMT_PCM   = 16'h0001;
	localparam logic [15:0] FMT_FLOAT = 16'h0003;
	localparam logic [15:0] FMT_EXT   = 16'hFFFE;

	// Status codes
	localparam logic [3:0] SC_OK     = 4'd0;
	localparam logic [3:0] SC_SHORT  = 4'd1;
	localparam logic [3:0] SC_FLAC   = 4'd2;
	localparam logic [3:0] SC_OGG    = 4'd3;
	localparam logic [3:0] SC_RIFF   = 4'd4;
	localparam logic [3:0] SC_MP4    = 4'd5;
	localparam logic [3:0] SC_MP3    = 4'd6;
	localparam logic [3:0] SC_NOTWAV = 4'd7;
	localparam logic [3:0] SC_TRUNC  = 4'd8;
	localparam logic [3:0] SC_NOFMT  = 4'd9;
	localparam logic [3:0] SC_NODATA = 4'd10;
	localparam logic [3:0] SC_CODEC  = 4'd11;
	localparam logic [3:0] SC_ZERO   = 4'd12;
	localparam logic [3:0] SC_BITS   = 4'd13;
	localparam logic [3:0] SC_NOFRM  = 4'd14;
	localparam logic [3:0] SC_MANYCH = 4'd15;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic conv;
		logic div_step;
		logic load_smp;
		logic load_sts;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fin;
		logic smp_done;
		logic frame_done;
		logic div_last;
	} sts_t;

endpackage

/* rtl/wsd_ctrl.sv */
`include "wav_stream_decoder_mono_macros.svh"

module wsd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_stall,
	output logic          result_valid,
	input  logic          result_stall,
	input  wsd_pkg::sts_t sts,
	output wsd_pkg::cmd_t cmd
);
	import wsd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_CONV = 6'b000100,
		S_DIV  = 6'b001000,
		S_SOUT = 6'b010000,
		S_TOUT = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic   valid_q, valid_n;
	logic   free;

	// Output register can take a word this cycle
	assign free = !valid_q || !result_stall;

	// Sequence one byte through parse, convert, divide and emit
	always_comb begin
		state_n = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (byte_valid) begin
					cmd.take = 1'b1;
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.smp_done) state_n = S_CONV;
				else if (sts.fin) state_n = S_TOUT;
				else state_n = S_IDLE;
			end
			S_CONV: begin
				cmd.conv = 1'b1;
				if (sts.frame_done) state_n = S_DIV;
				else if (sts.fin) state_n = S_TOUT;
				else state_n = S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_n = S_SOUT;
			end
			S_SOUT: begin
				if (free) begin
					cmd.load_smp = 1'b1;
					state_n = sts.fin ? S_TOUT : S_IDLE;
				end
			end
			S_TOUT: begin
				if (free) begin
					cmd.load_sts = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Hold the output word until taken
	always_comb begin
		valid_n = valid_q;
		if (cmd.load_smp || cmd.load_sts) valid_n = 1'b1;
		else if (!result_stall) valid_n = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			valid_q <= valid_n;
		end
	end

	assign byte_stall   = (state_q != S_IDLE);
	assign result_valid = valid_q;

	`WSD_ASSERT_NXT(a_div_exit, state_q == S_DIV, state_q == S_DIV || state_q == S_SOUT)
	`WSD_ASSERT_NXT(a_sts_out, cmd.load_sts, valid_q && state_q == S_IDLE)

endmodule

/* rtl/wsd_dp.sv */
`include "wav_stream_decoder_mono_macros.svh"

module wsd_dp #(
	parameter int MAX_CHANNELS = wsd_pkg::MAX_CH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         file_byte,
	input  logic               final_byte,
	input  wsd_pkg::cmd_t      cmd,
	output wsd_pkg::sts_t      sts,
	output logic               is_status,
	output logic signed [23:0] mono_sample,
	output logic [3:0]         status_code,
	output logic [31:0]        sample_rate,
	output logic               end_of_run
);
	import wsd_pkg::*;

	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int SUM_W = 24 + CH_W;
	localparam int DC_W  = $clog2(SUM_W);
	localparam logic [DC_W-1:0]  DC_LAST = DC_W'(SUM_W - 1);
	localparam logic [SUM_W-1:0] MAG_MIN = SUM_W'(24'h800000);

	typedef enum logic [5:0] {
		P_HDR  = 6'b000001,
		P_CHDR = 6'b000010,
		P_BODY = 6'b000100,
		P_DATA = 6'b001000,
		P_PAD  = 6'b010000,
		P_SINK = 6'b100000
	} parse_t;

	logic [7:0]        byte_q, byte_n;
	logic              fin_q, fin_n;
	parse_t            stage_q, stage_n;
	logic [87:0]       hdr_q, hdr_n;
	logic [3:0]        hcnt_q, hcnt_n;
	logic [31:0]       tag_q, tag_n;
	logic [31:0]       left_q, left_n;
	logic              pad_q, pad_n;
	logic [4:0]        pos_q, pos_n;
	logic [15:0]       ftag_q, ftag_n;
	logic [15:0]       chan_q, chan_n;
	logic [31:0]       rate_q, rate_n;
	logic [15:0]       bits_q, bits_n;
	logic              fseen_q, fseen_n;
	logic              dseen_q, dseen_n;
	logic [63:0]       smp_q, smp_n;
	logic [3:0]        bis_q, bis_n;
	logic [CH_W-1:0]   idx_q, idx_n;
	logic [SUM_W-1:0]  sum_q, sum_n;
	logic              frm_q, frm_n;
	logic [3:0]        err_q, err_n;
	logic [7:0]        sub_q, sub_n;
	logic              fact_q, fact_n;
	logic [SUM_W-1:0]  dvd_q, dvd_n;
	logic [CH_W:0]     rem_q, rem_n;
	logic [DC_W-1:0]   dcnt_q, dcnt_n;
	logic              neg_q, neg_n;
	logic              ost_q, ost_n;
	logic [23:0]       omono_q, omono_n;
	logic [3:0]        ocode_q, ocode_n;
	logic [31:0]       orate_q, orate_n;
	logic              oeor_q, oeor_n;

	logic [31:0]       tag_w, left_w;
	logic [4:0]        pos_inc;
	logic [3:0]        bps, bis_inc;
	logic [23:0]       conv_v;
	logic [SUM_W-1:0]  sum_w;
	logic [CH_W-1:0]   idx_inc;
	logic [CH_W:0]     rem_sh;
	logic [SUM_W-1:0]  qv;
	logic [3:0]        hdr_code, fmt_code, st_code;
	logic              smp_done, frame_done;

	function automatic logic [3:0] classify(input logic [95:0] h);
		logic riff;
		riff = (h[31:0] == 32'h46464952);
		if (riff && h[95:64] == 32'h45564157) return SC_OK;
		if (h[31:0] == 32'h43614C66) return SC_FLAC;
		if (h[31:0] == 32'h5367674F) return SC_OGG;
		if (riff) return SC_RIFF;
		if (h[63:32] == 32'h70797466) return SC_MP4;
		if (h[23:0] == 24'h334449) return SC_MP3;
		if (h[7:0] == 8'hFF && h[15:13] == 3'b111) return SC_MP3;
		return SC_NOTWAV;
	endfunction

	function automatic logic [23:0] sat_mag(input logic neg, input logic [24:0] mag);
		logic [24:0] nm;
		nm = 25'd0 - mag;
		if (neg) return (mag >= 25'h0800000) ? 24'h800000 : nm[23:0];
		return (mag > 25'h07FFFFF) ? 24'h7FFFFF : mag[23:0];
	endfunction

	function automatic logic [23:0] to_q23(input logic [63:0] raw, input logic [15:0] ft,
			input logic [15:0] bd);
		logic [7:0]  s8;
		logic [10:0] s11;
		logic [23:0] t24;
		logic [52:0] t53;
		logic [32:0] m33;
		s8  = 8'd127 - raw[30:23];
		s11 = 11'd1052 - raw[62:52];
		t24 = {1'b1, raw[22:0]} >> s8[4:0];
		t53 = {1'b1, raw[51:0]} >> s11[5:0];
		m33 = raw[31] ? (33'h100000000 - {1'b0, raw[31:0]}) : {1'b0, raw[31:0]};
		if (ft == FMT_FLOAT) begin
			if (bd == 16'd32) begin
				if (raw[30:23] == 8'hFF)
					return (raw[22:0] != 23'd0) ? 24'd0 : sat_mag(raw[31], 25'h1000000);
				if (raw[30:23] == 8'h00) return 24'd0;
				if (raw[30:23] >= 8'd127) return sat_mag(raw[31], 25'h1000000);
				if (s8 >= 8'd32) return 24'd0;
				return sat_mag(raw[31], {1'b0, t24});
			end
			if (raw[62:52] == 11'h7FF)
				return (raw[51:0] != 52'd0) ? 24'd0 : sat_mag(raw[63], 25'h1000000);
			if (raw[62:52] == 11'h000) return 24'd0;
			if (raw[62:52] >= 11'd1023) return sat_mag(raw[63], 25'h1000000);
			if (s11 >= 11'd64) return 24'd0;
			return sat_mag(raw[63], t53[24:0]);
		end
		case (bd)
			16'd8:   return {~raw[7], raw[6:0], 16'd0};
			16'd16:  return {raw[15:0], 8'd0};
			16'd24:  return raw[23:0];
			default: return sat_mag(raw[31], m33[32:8]);
		endcase
	endfunction

	// Format checks when the first data chunk opens
	always_comb begin
		if (!fseen_q) fmt_code = SC_NOFMT;
		else if (ftag_q != FMT_PCM && ftag_q != FMT_FLOAT) fmt_code = SC_CODEC;
		else if (chan_q == 16'd0 || rate_q == 32'd0) fmt_code = SC_ZERO;
		else if (ftag_q == FMT_FLOAT && bits_q != 16'd32 && bits_q != 16'd64)
			fmt_code = SC_BITS;
		else if (ftag_q == FMT_PCM && bits_q != 16'd8 && bits_q != 16'd16 &&
				bits_q != 16'd24 && bits_q != 16'd32)
			fmt_code = SC_BITS;
		else if (chan_q > 16'(MAX_CHANNELS)) fmt_code = SC_MANYCH;
		else fmt_code = SC_OK;
	end

	// Final status, in priority order
	always_comb begin
		if (stage_q == P_HDR) st_code = SC_SHORT;
		else if (err_q != SC_OK) st_code = err_q;
		else if ((stage_q == P_BODY || stage_q == P_DATA) && left_q != 32'd0 &&
				(pos_q == 5'd0 || tag_q != TAG_DATA))
			st_code = SC_TRUNC;
		else if (!dseen_q) st_code = fseen_q ? SC_NODATA : SC_NOFMT;
		else if (!frm_q) st_code = SC_NOFRM;
		else st_code = SC_OK;
	end

	// Shared helpers
	always_comb begin
		tag_w = tag_q;
		left_w = left_q;
		if (pos_q < 5'd4) tag_w[{pos_q[1:0], 3'b000} +: 8] = byte_q;
		else left_w[{pos_q[1:0], 3'b000} +: 8] = byte_q;
	end

	assign hdr_code = classify({byte_q, hdr_q});
	assign pos_inc  = (pos_q == 5'h1F) ? pos_q : pos_q + 5'd1;
	assign bps      = (bits_q[5:3] == 3'd0) ? 4'd8 : {1'b0, bits_q[5:3]};
	assign bis_inc  = bis_q + 4'd1;
	assign conv_v   = to_q23(smp_q, ftag_q, bits_q);
	assign sum_w    = sum_q + {{CH_W{conv_v[23]}}, conv_v};
	assign idx_inc  = idx_q + CH_W'(1);
	assign rem_sh   = {rem_q[CH_W-1:0], dvd_q[SUM_W-1]};
	assign qv       = neg_q ? (SUM_W'(0) - dvd_q) : dvd_q;

	// Next-state logic for parse, convert, divide and output
	always_comb begin
		byte_n = byte_q;   fin_n = fin_q;     stage_n = stage_q; hdr_n = hdr_q;
		hcnt_n = hcnt_q;   tag_n = tag_q;     left_n = left_q;   pad_n = pad_q;
		pos_n = pos_q;     ftag_n = ftag_q;   chan_n = chan_q;   rate_n = rate_q;
		bits_n = bits_q;   fseen_n = fseen_q; dseen_n = dseen_q; smp_n = smp_q;
		bis_n = bis_q;     idx_n = idx_q;     sum_n = sum_q;     frm_n = frm_q;
		err_n = err_q;     sub_n = sub_q;     fact_n = fact_q;   dvd_n = dvd_q;
		rem_n = rem_q;     dcnt_n = dcnt_q;   neg_n = neg_q;     ost_n = ost_q;
		omono_n = omono_q; ocode_n = ocode_q; orate_n = orate_q; oeor_n = oeor_q;
		smp_done = 1'b0;
		frame_done = 1'b0;

		// Latch the incoming word
		if (cmd.take) begin
			byte_n = file_byte;
			fin_n = final_byte;
		end

		// Advance the chunk parser by one byte
		if (cmd.exec) begin
			case (stage_q)
				P_HDR: begin
					if (hcnt_q < 4'd11) begin
						hdr_n[{hcnt_q, 3'b000} +: 8] = byte_q;
						hcnt_n = hcnt_q + 4'd1;
					end else begin
						err_n = hdr_code;
						stage_n = (hdr_code != SC_OK) ? P_SINK : P_CHDR;
						pos_n = 5'd0;
					end
				end
				P_CHDR: begin
					tag_n = tag_w;
					left_n = left_w;
					pos_n = pos_q + 5'd1;
					if (pos_q == 5'd7) begin
						pos_n = 5'd0;
						pad_n = left_w[0];
						fact_n = (tag_w == TAG_FMT) && (left_w >= 32'd16) && !dseen_q;
						if (left_w == 32'd0) begin
							stage_n = P_CHDR;
							tag_n = 32'd0;
						end else if (tag_w == TAG_DATA && !dseen_q) begin
							dseen_n = 1'b1;
							err_n = fmt_code;
							if (fmt_code != SC_OK) stage_n = P_SINK;
							else begin
								stage_n = P_DATA;
								smp_n = 64'd0;
								bis_n = 4'd0;
								idx_n = '0;
								sum_n = '0;
							end
						end else begin
							stage_n = P_BODY;
						end
					end
				end
				P_BODY: begin
					if (fact_q) begin
						case (pos_q)
							5'd0:  ftag_n = {8'd0, byte_q};
							5'd1:  ftag_n[15:8] = byte_q;
							5'd2:  chan_n = {8'd0, byte_q};
							5'd3:  chan_n[15:8] = byte_q;
							5'd4:  rate_n = {24'd0, byte_q};
							5'd5, 5'd6, 5'd7: rate_n[{pos_q[1:0], 3'b000} +: 8] = byte_q;
							5'd14: bits_n = {8'd0, byte_q};
							5'd15: bits_n[15:8] = byte_q;
							5'd24: sub_n = byte_q;
							5'd25: if (ftag_q == FMT_EXT) ftag_n = {byte_q, sub_q};
							default: ;
						endcase
					end
					pos_n = pos_inc;
					left_n = left_q - 32'd1;
					if (left_q == 32'd1) begin
						if (fact_q) fseen_n = 1'b1;
						fact_n = 1'b0;
						stage_n = pad_q ? P_PAD : P_CHDR;
						pos_n = 5'd0;
						tag_n = 32'd0;
						left_n = 32'd0;
					end
				end
				P_DATA: begin
					smp_n[{bis_q[2:0], 3'b000} +: 8] = byte_q;
					bis_n = bis_inc;
					if (bis_inc >= bps) begin
						smp_done = 1'b1;
						bis_n = 4'd0;
					end
					pos_n = pos_inc;
					left_n = left_q - 32'd1;
					if (left_q == 32'd1) begin
						stage_n = pad_q ? P_PAD : P_CHDR;
						pos_n = 5'd0;
						tag_n = 32'd0;
						left_n = 32'd0;
					end
				end
				P_PAD: begin
					stage_n = P_CHDR;
					pos_n = 5'd0;
				end
				default: ;
			endcase
		end

		// Accumulate one converted sample, start the divide at frame end
		if (cmd.conv) begin
			smp_n = 64'd0;
			if (idx_inc >= chan_q[CH_W-1:0]) begin
				frame_done = 1'b1;
				idx_n = '0;
				sum_n = '0;
				neg_n = sum_w[SUM_W-1];
				dvd_n = sum_w[SUM_W-1] ? (SUM_W'(0) - sum_w) : sum_w;
				rem_n = '0;
				dcnt_n = '0;
			end else begin
				idx_n = idx_inc;
				sum_n = sum_w;
			end
		end

		// One restoring divide step per cycle
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, chan_q[CH_W-1:0]}) begin
				rem_n = rem_sh - {1'b0, chan_q[CH_W-1:0]};
				dvd_n = {dvd_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_n = rem_sh;
				dvd_n = {dvd_q[SUM_W-2:0], 1'b0};
			end
			dcnt_n = dcnt_q + DC_W'(1);
		end

		// Load a sample word
		if (cmd.load_smp) begin
			ost_n = 1'b0;
			omono_n = qv[23:0];
			ocode_n = SC_OK;
			orate_n = 32'd0;
			oeor_n = !fin_q;
			frm_n = 1'b1;
		end

		// Load the status word and drop all file state
		if (cmd.load_sts) begin
			ost_n = 1'b1;
			omono_n = 24'd0;
			ocode_n = st_code;
			orate_n = (st_code == SC_OK) ? rate_q : 32'd0;
			oeor_n = 1'b1;
			stage_n = P_HDR; hdr_n = '0;    hcnt_n = '0;    tag_n = '0;
			left_n = '0;     pad_n = 1'b0;  pos_n = '0;     ftag_n = '0;
			chan_n = '0;     rate_n = '0;   bits_n = '0;    fseen_n = 1'b0;
			dseen_n = 1'b0;  smp_n = '0;    bis_n = '0;     idx_n = '0;
			sum_n = '0;      frm_n = 1'b0;  err_n = SC_OK;  sub_n = '0;
			fact_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;   fin_q <= 1'b0;   stage_q <= P_HDR; hdr_q <= '0;
			hcnt_q <= '0;   tag_q <= '0;     left_q <= '0;     pad_q <= 1'b0;
			pos_q <= '0;    ftag_q <= '0;    chan_q <= '0;     rate_q <= '0;
			bits_q <= '0;   fseen_q <= 1'b0; dseen_q <= 1'b0;  smp_q <= '0;
			bis_q <= '0;    idx_q <= '0;     sum_q <= '0;      frm_q <= 1'b0;
			err_q <= SC_OK; sub_q <= '0;     fact_q <= 1'b0;   dvd_q <= '0;
			rem_q <= '0;    dcnt_q <= '0;    neg_q <= 1'b0;    ost_q <= 1'b0;
			omono_q <= '0;  ocode_q <= '0;   orate_q <= '0;    oeor_q <= 1'b0;
		end else begin
			byte_q <= byte_n;   fin_q <= fin_n;     stage_q <= stage_n; hdr_q <= hdr_n;
			hcnt_q <= hcnt_n;   tag_q <= tag_n;     left_q <= left_n;   pad_q <= pad_n;
			pos_q <= pos_n;     ftag_q <= ftag_n;   chan_q <= chan_n;   rate_q <= rate_n;
			bits_q <= bits_n;   fseen_q <= fseen_n; dseen_q <= dseen_n; smp_q <= smp_n;
			bis_q <= bis_n;     idx_q <= idx_n;     sum_q <= sum_n;     frm_q <= frm_n;
			err_q <= err_n;     sub_q <= sub_n;     fact_q <= fact_n;   dvd_q <= dvd_n;
			rem_q <= rem_n;     dcnt_q <= dcnt_n;   neg_q <= neg_n;     ost_q <= ost_n;
			omono_q <= omono_n; ocode_q <= ocode_n; orate_q <= orate_n; oeor_q <= oeor_n;
		end
	end

	assign sts.fin        = fin_q;
	assign sts.smp_done   = smp_done;
	assign sts.frame_done = frame_done;
	assign sts.div_last   = (dcnt_q == DC_LAST);

	assign is_status   = ost_q;
	assign mono_sample = omono_q;
	assign status_code = ocode_q;
	assign sample_rate = orate_q;
	assign end_of_run  = oeor_q;

	`WSD_ASSERT_IMP(a_avg_fits, cmd.load_smp, dvd_q[SUM_W-1:23] == '0 || (neg_q && dvd_q == MAG_MIN))
	`WSD_ASSERT_IMP(a_err_sink, err_q != SC_OK, stage_q == P_SINK)
	`WSD_ASSERT_IMP(a_data_fmt, stage_q == P_DATA, dseen_q && fseen_q)

endmodule

/* rtl/wav_stream_decoder_mono.sv */
// Channel | Handshake                  | Payload
// byte    | byte_valid / byte_stall    | file_byte, final_byte
// result  | result_valid / result_stall| is_status, mono_sample, status_code,
//         |                            | sample_rate, end_of_run
//
// A byte passes through the take and parse states; one that completes a sample
// adds a convert state, and one that completes a frame adds the restoring
// divider steps plus an output load, which waits while a held word is stalled.
// Reset is asynchronous and active low; no clearing pass follows it.
// A waiting result word holds in the output register while the next byte
// is taken; a new word loads only once the previous one has gone.
module wav_stream_decoder_mono #(
	parameter int MAX_CHANNELS = wsd_pkg::MAX_CH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         file_byte,
	input  logic               final_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               is_status,
	output logic signed [23:0] mono_sample,
	output logic [3:0]         status_code,
	output logic [31:0]        sample_rate,
	output logic               end_of_run
);
	import wsd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	wsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Parser, converter, divider and output register
	wsd_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_byte   (file_byte),
		.final_byte  (final_byte),
		.cmd         (cmd),
		.sts         (sts),
		.is_status   (is_status),
		.mono_sample (mono_sample),
		.status_code (status_code),
		.sample_rate (sample_rate),
		.end_of_run  (end_of_run)
	);

endmodule

/* sim/wav_stream_decoder_mono_tb.sv */
`timescale 1ns / 1ps

module wav_stream_decoder_mono_tb;
	import wsd_pkg::*;

	localparam int MAXCH = MAX_CH_DEF;
	localparam int LIMIT_CYCLES = 1500000;

	// Parse stages of the decoder
	typedef enum logic [2:0] {
		PS_HEADER, PS_CHDR, PS_BODY, PS_DATA, PS_PAD, PS_SINK
	} parse_stage_e;

	typedef struct packed {
		logic               is_status;
		logic signed [23:0] mono_sample;
		logic [3:0]         status_code;
		logic [31:0]        sample_rate;
		logic               end_of_run;
	} result_word_t;

	// Expected result words and the decoder state that predicts them
	class wav_scoreboard;
		result_word_t pending[$];
		int errors;
		logic [31:0]  offset;
		parse_stage_e stage;
		logic [7:0]   hdr[12];
		logic [31:0]  tag, left;
		logic         pad, fmt_ok, data_ok, fmt_live;
		logic [15:0]  ftag, nch, bits;
		logic [31:0]  rate;
		logic [63:0]  acc;
		logic [15:0]  chi;
		logic signed [31:0] fsum;
		logic [31:0]  nframes;
		logic [3:0]   err;
		logic [31:0]  pos;
		logic [7:0]   bis, sublo;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			offset = 0; stage = PS_HEADER;
			foreach (hdr[i]) hdr[i] = 0;
			tag = 0; left = 0; pad = 0; fmt_ok = 0; data_ok = 0; fmt_live = 0;
			ftag = 0; nch = 0; bits = 0; rate = 0; acc = 0; chi = 0; fsum = 0;
			nframes = 0; err = SC_OK; pos = 0; bis = 0; sublo = 0;
		endfunction

		function bit hdr_match(int at, logic [31:0] w);
			return hdr[at] == w[31:24] && hdr[at+1] == w[23:16] &&
				hdr[at+2] == w[15:8] && hdr[at+3] == w[7:0];
		endfunction

		function logic [3:0] container_code();
			bit riff;
			riff = hdr_match(0, 32'h52494646);
			if (riff && hdr_match(8, 32'h57415645)) return SC_OK;
			if (hdr_match(0, 32'h664C6143)) return SC_FLAC;
			if (hdr_match(0, 32'h4F676753)) return SC_OGG;
			if (riff) return SC_RIFF;
			if (hdr_match(4, 32'h66747970)) return SC_MP4;
			if (hdr[0] == 8'h49 && hdr[1] == 8'h44 && hdr[2] == 8'h33) return SC_MP3;
			if (hdr[0] == 8'hFF && (hdr[1] & 8'hE0) == 8'hE0) return SC_MP3;
			return SC_NOTWAV;
		endfunction

		function logic signed [31:0] clamp(bit neg, logic [63:0] mag);
			if (neg) return (mag >= 64'h800000) ? -32'sd8388608 : -$signed({1'b0, mag[30:0]});
			return (mag > 64'h7FFFFF) ? 32'sd8388607 : $signed({1'b0, mag[30:0]});
		endfunction

		function logic signed [31:0] to_q23(logic [63:0] raw);
			logic [31:0] e, s;
			logic [63:0] m, mag;
			bit neg;
			if (ftag == FMT_FLOAT) begin
				if (bits == 32) begin
					neg = raw[31]; e = raw[30:23]; m = raw[22:0];
					if (e == 255) return (m != 0) ? 0 : clamp(neg, 64'h1000000);
					if (e == 0) return 0;
					if (e >= 127) return clamp(neg, 64'h1000000);
					s = 127 - e;
					return (s >= 32) ? 0 : clamp(neg, (m | 64'h800000) >> s);
				end
				neg = raw[63]; e = raw[62:52]; m = raw[51:0];
				if (e == 2047) return (m != 0) ? 0 : clamp(neg, 64'h1000000);
				if (e == 0) return 0;
				if (e >= 1023) return clamp(neg, 64'h1000000);
				s = 1052 - e;
				return (s >= 64) ? 0 : clamp(neg, (m | (64'd1 << 52)) >> s);
			end
			case (bits)
				8: return ($signed({24'd0, raw[7:0]}) - 128) * 65536;
				16: return $signed({{16{raw[15]}}, raw[15:0]}) * 256;
				24: return $signed({{8{raw[23]}}, raw[23:0]});
				default: begin
					neg = raw[31];
					mag = neg ? (64'h100000000 - raw[31:0]) : raw[31:0];
					return clamp(neg, mag >> 8);
				end
			endcase
		endfunction

		function logic [3:0] format_code();
			if (!fmt_ok) return SC_NOFMT;
			if (ftag != FMT_PCM && ftag != FMT_FLOAT) return SC_CODEC;
			if (nch == 0 || rate == 0) return SC_ZERO;
			if (ftag == FMT_FLOAT) begin
				if (bits != 32 && bits != 64) return SC_BITS;
			end else if (bits != 8 && bits != 16 && bits != 24 && bits != 32) begin
				return SC_BITS;
			end
			if (nch > MAXCH) return SC_MANYCH;
			return SC_OK;
		endfunction

		function void end_body();
			stage = pad ? PS_PAD : PS_CHDR;
			pos = 0; tag = 0; left = 0;
		endfunction

		function void push(bit st, logic signed [23:0] smp, logic [3:0] code,
				logic [31:0] r, bit eor);
			result_word_t w;
			w.is_status = st; w.mono_sample = smp; w.status_code = code;
			w.sample_rate = r; w.end_of_run = eor;
			pending.push_back(w);
		endfunction

		// Note one accepted byte and queue the words it causes
		function void note_byte(logic [7:0] b, bit fin);
			logic [31:0] bps;
			logic [3:0] code;
			logic signed [31:0] avg;
			case (stage)
				PS_HEADER: begin
					if (offset < 12) hdr[offset] = b;
					if (offset >= 11) begin
						err = container_code();
						stage = (err != SC_OK) ? PS_SINK : PS_CHDR;
						pos = 0;
					end
				end
				PS_CHDR: begin
					if (pos < 4) tag |= 32'(b) << (8 * pos);
					else left |= 32'(b) << (8 * (pos - 4));
					pos++;
					if (pos == 8) begin
						pos = 0;
						pad = left[0];
						fmt_live = tag == TAG_FMT && left >= 16 && !data_ok;
						if (left == 0) end_body();
						else if (tag == TAG_DATA && !data_ok) begin
							data_ok = 1;
							err = format_code();
							if (err != SC_OK) stage = PS_SINK;
							else begin
								stage = PS_DATA; acc = 0; bis = 0; chi = 0; fsum = 0;
							end
						end else stage = PS_BODY;
					end
				end
				PS_BODY: begin
					if (fmt_live) begin
						case (pos)
							0: ftag = b;
							1: ftag[15:8] = b;
							2: nch = b;
							3: nch[15:8] = b;
							4: rate = b;
							5, 6, 7: rate |= 32'(b) << (8 * (pos - 4));
							14: bits = b;
							15: bits[15:8] = b;
							24: sublo = b;
							25: if (ftag == FMT_EXT) ftag = {b, sublo};
							default: ;
						endcase
					end
					if (pos < 32'hFFFF) pos++;
					left--;
					if (left == 0) begin
						if (fmt_live) fmt_ok = 1;
						fmt_live = 0;
						end_body();
					end
				end
				PS_DATA: begin
					bps = (bits / 8) & 7;
					if (bps == 0) bps = 8;
					acc |= 64'(b) << (8 * bis[2:0]);
					bis++;
					if (bis >= bps) begin
						fsum += to_q23(acc);
						acc = 0; bis = 0; chi++;
						if (chi >= nch) begin
							avg = (nch != 0) ? fsum / $signed({16'd0, nch}) : 0;
							push(0, avg[23:0], SC_OK, 0, !fin);
							if (nframes != 32'hFFFFFFFF) nframes++;
							fsum = 0; chi = 0;
						end
					end
					if (pos < 32'hFFFF) pos++;
					left--;
					if (left == 0) end_body();
				end
				PS_PAD: begin
					stage = PS_CHDR; pos = 0;
				end
				default: ;
			endcase
			if (offset != 32'hFFFFFFFF) offset++;
			if (fin) begin
				if (stage == PS_HEADER) code = SC_SHORT;
				else if (err != SC_OK) code = err;
				else if ((stage == PS_BODY || stage == PS_DATA) && left != 0 &&
						(pos == 0 || tag != TAG_DATA)) code = SC_TRUNC;
				else if (!data_ok) code = fmt_ok ? SC_NODATA : SC_NOFMT;
				else if (nframes == 0) code = SC_NOFRM;
				else code = SC_OK;
				push(1, 0, code, (code == SC_OK) ? rate : 0, 1);
				clear();
			end
		endfunction

		// Compare one accepted word with the oldest expectation
		function void check_word(result_word_t got);
			result_word_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, got);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.is_status !== w.is_status)
				$display("%0t: is_status exp %0d got %0d", $realtime, w.is_status, got.is_status);
			if (got.mono_sample !== w.mono_sample)
				$display("%0t: mono_sample exp %0d got %0d", $realtime,
					w.mono_sample, got.mono_sample);
			if (got.status_code !== w.status_code)
				$display("%0t: status_code exp %0d got %0d", $realtime,
					w.status_code, got.status_code);
			if (got.sample_rate !== w.sample_rate)
				$display("%0t: sample_rate exp %0d got %0d", $realtime,
					w.sample_rate, got.sample_rate);
			if (got.end_of_run !== w.end_of_run)
				$display("%0t: end_of_run exp %0d got %0d", $realtime,
					w.end_of_run, got.end_of_run);
			if (got !== w) errors++;
		endfunction
	endclass

	logic clk, arst_n;
	logic byte_valid, byte_stall, final_byte;
	logic [7:0] file_byte;
	logic result_valid, result_stall;
	logic is_status, end_of_run;
	logic signed [23:0] mono_sample;
	logic [3:0] status_code;
	logic [31:0] sample_rate;

	wav_stream_decoder_mono u_top (.*);

	wav_scoreboard sb;
	logic [7:0] file_buf[$];
	int bytes_sent;
	int cycle_count;
	bit sending_done;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Return a gap length: mostly short, sometimes long
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	bit idle_phase;

	// Send one word and wait for it to be taken
	task automatic send_byte(logic [7:0] b, bit fin);
		int g;
		g = idle_phase ? 0 : gap_len();
		// Hold valid low between words, longer by a random gap outside the idle phase
		repeat (g + 1) @(negedge clk);
		byte_valid <= 1; file_byte <= b; final_byte <= fin;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
		byte_valid <= 0;
	endtask

	// Send the buffered file
	task automatic send_file();
		int n;
		n = file_buf.size();
		for (int i = 0; i < n; i++) send_byte(file_buf[i], i == n - 1);
		file_buf.delete();
	endtask

	function void put_bytes(logic [31:0] v, int n);
		for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
	endfunction

	function void put_hdr();
		put_bytes(32'h46464952, 4); put_bytes($urandom, 4); put_bytes(32'h45564157, 4);
	endfunction

	function void put_fmt(logic [15:0] ft, logic [15:0] ch, logic [31:0] r,
			logic [15:0] bt, int len, logic [15:0] sub);
		put_bytes(TAG_FMT, 4); put_bytes(len, 4);
		for (int i = 0; i < len; i++) begin
			case (i)
				0: file_buf.push_back(ft[7:0]);
				1: file_buf.push_back(ft[15:8]);
				2: file_buf.push_back(ch[7:0]);
				3: file_buf.push_back(ch[15:8]);
				4, 5, 6, 7: file_buf.push_back(r[8*(i-4) +: 8]);
				14: file_buf.push_back(bt[7:0]);
				15: file_buf.push_back(bt[15:8]);
				24: file_buf.push_back(sub[7:0]);
				25: file_buf.push_back(sub[15:8]);
				default: file_buf.push_back($urandom);
			endcase
		end
		if (len % 2) file_buf.push_back(0);
	endfunction

	function void put_chunk(logic [31:0] tg, int len);
		put_bytes(tg, 4); put_bytes(len, 4);
		for (int i = 0; i < len; i++) file_buf.push_back($urandom);
		if (len % 2) file_buf.push_back(0);
	endfunction

	// Random sample bytes, with float exponents biased near the interesting range
	function void put_sample(logic [15:0] ft, logic [15:0] bt);
		logic [63:0] v;
		int k;
		v = {$urandom, $urandom};
		k = $urandom_range(0, 9);
		if (ft == FMT_FLOAT && bt == 32 && k < 7) v[30:23] = $urandom_range(100, 128);
		if (ft == FMT_FLOAT && bt == 32 && k == 7) v[30:23] = 8'hFF;
		if (ft == FMT_FLOAT && bt == 64 && k < 7) v[62:52] = $urandom_range(990, 1026);
		if (ft == FMT_FLOAT && bt == 64 && k == 7) v[62:52] = 11'h7FF;
		if (k == 8) v = 0;
		for (int i = 0; i < bt / 8; i++) file_buf.push_back(v[8*i +: 8]);
	endfunction

	// Build a well-formed file, sometimes cut short or bent
	task automatic random_wav();
		logic [15:0] ft, ch, bt, sub;
		int frames, dlen, cut, kind;
		kind = $urandom_range(0, 3);
		ft = kind == 0 ? FMT_FLOAT : (kind == 1 ? FMT_EXT : FMT_PCM);
		sub = $urandom_range(0, 1) ? FMT_FLOAT : FMT_PCM;
		case ($urandom_range(0, 3))
			0: bt = 8; 1: bt = 16; 2: bt = 24; default: bt = 32;
		endcase
		if ((ft == FMT_FLOAT || (ft == FMT_EXT && sub == FMT_FLOAT)) &&
				$urandom_range(0, 1)) bt = 64;
		if ((ft == FMT_FLOAT || (ft == FMT_EXT && sub == FMT_FLOAT)) && bt < 32) bt = 32;
		ch = $urandom_range(0, 9) == 0 ? MAXCH : $urandom_range(1, 3);
		put_hdr();
		if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5));
		put_fmt(ft, ch, $urandom_range(0, 9) == 0 ? 32'hFFFFFFFF : $urandom_range(1, 96000),
			bt, ft == FMT_EXT ? 40 : ($urandom_range(0, 1) ? 16 : 18), sub);
		frames = $urandom_range(1, 4);
		dlen = frames * ch * bt / 8 + ($urandom_range(0, 3) == 0 ? 1 : 0);
		put_bytes(TAG_DATA, 4); put_bytes(dlen, 4);
		for (int f = 0; f < frames * ch; f++)
			put_sample(ft == FMT_EXT ? sub : ft, bt);
		if (dlen % 2) begin
			file_buf.push_back($urandom);
			file_buf.push_back(0);
		end
		if ($urandom_range(0, 2) == 0) put_chunk(TAG_DATA, $urandom_range(1, 4));
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, file_buf.size() - 1);
			while (file_buf.size() > cut) void'(file_buf.pop_back());
		end
		send_file();
	endtask

	// Random bytes, half the time behind a readable header
	task automatic noise_file();
		int n;
		n = $urandom_range(1, 30);
		if ($urandom_range(0, 1)) put_hdr();
		for (int i = 0; i < n; i++) file_buf.push_back($urandom);
		send_file();
	endtask

	task automatic wait_drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Drain the result channel with random stalls
	initial begin
		int g;
		result_stall = 1;
		forever begin
			@(negedge clk);
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				result_stall <= 1;
				repeat (g) @(negedge clk);
			end
			result_stall <= 0;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall)
			sb.check_word({is_status, mono_sample, status_code, sample_rate, end_of_run});

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		bytes_sent = 0; idle_phase = 0;
		arst_n = 0; byte_valid = 0; file_byte = 0; final_byte = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: containers, short file, extremes
		send_byte(8'hFF, 1);
		put_bytes(32'h43614C66, 4); put_bytes(0, 8); send_file();
		put_bytes(32'h5367674F, 4); put_bytes(0, 8); send_file();
		put_bytes(32'h46464952, 4); put_bytes(0, 8); send_file();
		put_bytes(0, 4); put_bytes(32'h70797466, 4); put_bytes(0, 4); send_file();
		put_bytes(32'h00334449, 4); put_bytes(0, 8); send_file();
		put_bytes(32'h0000E0FF, 4); put_bytes(0, 8); send_file();
		put_bytes(32'hFFFFFFFF, 4); put_bytes(32'hFFFFFFFF, 4); put_bytes(0, 4); send_file();
		// Data before fmt, fmt without data, short fmt
		put_hdr(); put_chunk(TAG_DATA, 2); send_file();
		put_hdr(); put_fmt(FMT_PCM, 1, 8000, 16, 16, 0); send_file();
		put_hdr(); put_chunk(TAG_FMT, 3); put_chunk(TAG_DATA, 2); send_file();
		// Bad codec, zero channels, bad bits, too many channels
		put_hdr(); put_fmt(16'h0055, 1, 8000, 16, 16, 0); put_chunk(TAG_DATA, 2); send_file();
		put_hdr(); put_fmt(FMT_PCM, 0, 8000, 16, 16, 0); put_chunk(TAG_DATA, 2); send_file();
		put_hdr(); put_fmt(FMT_PCM, 1, 8000, 12, 16, 0); put_chunk(TAG_DATA, 2); send_file();
		put_hdr(); put_fmt(FMT_PCM, MAXCH + 1, 8000, 8, 16, 0);
		put_chunk(TAG_DATA, 2); send_file();
		// Empty data, then no frames, then truncated header length
		put_hdr(); put_fmt(FMT_PCM, 2, 8000, 16, 16, 0); put_chunk(TAG_DATA, 0);
		put_chunk(TAG_DATA, 2); send_file();
		put_hdr(); put_fmt(FMT_PCM, 1, 8000, 16, 16, 0); put_bytes(TAG_DATA, 4);
		put_bytes(4, 4); send_file();
		put_hdr(); put_bytes(32'h74736C6C, 4); put_bytes(9, 4); put_bytes(0, 3); send_file();
		// Extreme PCM samples
		put_hdr(); put_fmt(FMT_PCM, 1, 44100, 8, 16, 0); put_bytes(TAG_DATA, 4);
		put_bytes(3, 4); put_bytes(32'h80FF00, 3); put_bytes(0, 1); send_file();
		put_hdr(); put_fmt(FMT_PCM, 2, 48000, 32, 16, 0); put_bytes(TAG_DATA, 4);
		put_bytes(16, 4); put_bytes(32'h80000000, 4); put_bytes(32'h80000000, 4);
		put_bytes(32'h7FFFFFFF, 4); put_bytes(32'h000000FF, 4); send_file();
		wait_drain();

		// Send one file with no gaps, then wait until everything has come back
		idle_phase = 1;
		random_wav();
		wait_drain();
		idle_phase = 0;

		while (bytes_sent < 600) begin
			if ($urandom_range(0, 9) < 8) random_wav();
			else noise_file();
			if ($urandom_range(0, 19) == 0) idle_phase = !idle_phase;
		end
		idle_phase = 0;
		wait_drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
